[design/pfbw_pkg.sv]
// Shared types and constants for the page frame buffer bit writer.
`default_nettype none

package pfbw_pkg;

    // Default geometry of the frame store
    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    // Requests held between the front end and the memory engine
    localparam int QUEUE_DEPTH = 2;

    // Byte and run constants
    localparam logic [7:0] BYTE_ONES = 8'hff;
    localparam logic [8:0] RUN_ONE   = 9'h001;
    localparam logic [3:0] LEN_MAX   = 4'd8;

    // Command codes on the request port
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Operation kinds after classification
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } t_op;

    // Classified request: hit0/hit1 say whether the first/second byte is touched
    typedef struct packed {
        t_op        op;
        logic       hit0;
        logic       hit1;
        logic [7:0] mask0;
        logic [7:0] val0;
        logic [7:0] mask1;
        logic [7:0] val1;
    } t_req;

    // Memory engine states
    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_READ,
        BS_WR0,
        BS_WR1
    } t_bstate;

endpackage

`default_nettype wire

[design/pfbw_front.sv]
// Front end: request acceptance and decode into byte masks and addresses.
`default_nettype none

module pfbw_front import pfbw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF,
    parameter int ADDR_W  = $clog2(COLUMNS_DEF * PAGES_DEF)
) (
    input  wire logic              i_start,
    input  wire logic [1:0]        i_command,
    input  wire logic [7:0]        i_x,
    input  wire logic [7:0]        i_y,
    input  wire logic [7:0]        i_data,
    input  wire logic [3:0]        i_len,
    input  wire logic              i_invert,
    input  wire logic              i_q_full,
    input  wire logic              i_init_busy,
    output logic                   o_busy,
    output logic                   o_push,
    output t_req                   o_req,
    output logic [ADDR_W-1:0]      o_addr0,
    output logic [ADDR_W-1:0]      o_addr1
);

    logic [3:0]  len_sat;
    logic [7:0]  run_mask;
    logic [7:0]  bits;
    logic [15:0] m16;
    logic [15:0] v16;
    logic [4:0]  page0;
    logic [5:0]  page1;
    logic        col_ok;
    logic        pg0_ok;
    logic        pg1_ok;
    logic [15:0] addr0_w;
    logic [15:0] addr1_w;

    // Handshake: take a request whenever the queue has room and the reset clearing sweep is over
    assign o_busy = i_q_full || i_init_busy;
    assign o_push = i_start && !o_busy;

    // Run mask and data aligned to the starting row
    always_comb begin
        len_sat  = (i_len > LEN_MAX) ? LEN_MAX : i_len;
        run_mask = (len_sat == LEN_MAX) ? BYTE_ONES : 8'((RUN_ONE << len_sat) - RUN_ONE);
        bits     = i_invert ? ~i_data : i_data;
        m16      = {8'h00, run_mask} << i_y[2:0];
        v16      = {8'h00, bits & run_mask} << i_y[2:0];
    end

    // Range checks and byte addresses of the two pages a run may touch
    always_comb begin
        page0   = i_y[7:3];
        page1   = {1'b0, page0} + 6'd1;
        col_ok  = {1'b0, i_x} < 9'(COLUMNS);
        pg0_ok  = {1'b0, page0} < 6'(PAGES);
        pg1_ok  = page1 < 6'(PAGES);
        addr0_w = 16'(page0) * 16'(COLUMNS) + 16'(i_x);
        addr1_w = addr0_w + 16'(COLUMNS);
    end

    assign o_addr0 = addr0_w[ADDR_W-1:0];
    assign o_addr1 = addr1_w[ADDR_W-1:0];

    // Classify the command
    always_comb begin
        o_req       = '0;
        o_req.op    = OP_NOP;
        o_req.mask0 = m16[7:0];
        o_req.val0  = v16[7:0];
        o_req.mask1 = m16[15:8];
        o_req.val1  = v16[15:8];
        case (t_cmd'(i_command))
            CMD_WRITE: begin
                o_req.op   = OP_WRITE;
                o_req.hit0 = col_ok && pg0_ok && (m16[7:0] != 8'h00);
                o_req.hit1 = col_ok && pg1_ok && (m16[15:8] != 8'h00);
            end
            CMD_READ: begin
                o_req.op   = OP_READ;
                o_req.hit0 = col_ok && pg0_ok;
            end
            CMD_CLEAR: begin
                o_req.op = OP_CLEAR;
            end
            default: begin
                o_req.op = OP_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/pfbw_queue.sv]
// Short request queue between the front end and the memory engine.
`default_nettype none

module pfbw_queue import pfbw_pkg::*; #(
    parameter int ADDR_W = $clog2(COLUMNS_DEF * PAGES_DEF)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire t_req              i_req,
    input  wire logic [ADDR_W-1:0] i_addr0,
    input  wire logic [ADDR_W-1:0] i_addr1,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output t_req                   o_req,
    output logic [ADDR_W-1:0]      o_addr0,
    output logic [ADDR_W-1:0]      o_addr1
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_req              r_req   [QUEUE_DEPTH];
    logic [ADDR_W-1:0] r_addr0 [QUEUE_DEPTH];
    logic [ADDR_W-1:0] r_addr1 [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_req   = r_req[r_rp];
    assign o_addr0 = r_addr0[r_rp];
    assign o_addr1 = r_addr1[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_req[r_wp]   <= i_req;
            r_addr0[r_wp] <= i_addr0;
            r_addr1[r_wp] <= i_addr1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("request popped from an empty queue");

endmodule

`default_nettype wire

[design/pfbw_back.sv]
// Memory engine: frame store, read-modify-write sequencing and clearing sweep.
`default_nettype none

module pfbw_back import pfbw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF,
    parameter int ADDR_W  = $clog2(COLUMNS_DEF * PAGES_DEF)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  wire t_req              i_req,
    input  wire logic [ADDR_W-1:0] i_addr0,
    input  wire logic [ADDR_W-1:0] i_addr1,
    output logic                   o_pop,
    output logic                   o_init_busy,
    output logic                   o_valid,
    output logic [7:0]             o_read_data
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    t_bstate           r_state;
    t_bstate           n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clr_cmd;
    t_req              r_cur;
    logic [ADDR_W-1:0] r_addr0;
    logic [ADDR_W-1:0] r_addr1;
    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rdata;
    logic              r_valid;
    logic [7:0]        r_read_data;
    logic              n_valid;
    logic [7:0]        n_read_data;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              clr_last;

    function automatic logic [7:0] merge(input logic [7:0] old, input logic [7:0] val,
                                         input logic [7:0] mask);
        merge = (old & ~mask) | (val & mask);
    endfunction

    assign clr_last    = (r_clr_addr == ADDR_LAST);
    assign o_init_busy = (r_state == BS_CLEAR) && !r_clr_cmd;
    assign o_valid     = r_valid;
    assign o_read_data = r_read_data;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_CLEAR: begin
                if (clr_last) n_state = BS_IDLE;
            end
            BS_IDLE: begin
                if (!i_empty) begin
                    case (i_req.op)
                        OP_WRITE: n_state = BS_WR0;
                        OP_READ:  n_state = BS_READ;
                        OP_CLEAR: n_state = BS_CLEAR;
                        default:  n_state = BS_IDLE;
                    endcase
                end
            end
            BS_READ: n_state = BS_IDLE;
            BS_WR0: begin
                n_state = r_cur.hit1 ? BS_WR1 : BS_IDLE;
            end
            BS_WR1:  n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    // Memory port control and result
    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = r_addr0;
        mem_wdata   = 8'h00;
        mem_re      = 1'b0;
        mem_raddr   = i_addr0;
        o_pop       = 1'b0;
        n_valid     = 1'b0;
        n_read_data = 8'h00;
        case (r_state)
            BS_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                n_valid   = clr_last && r_clr_cmd;
            end
            BS_IDLE: begin
                o_pop     = !i_empty;
                mem_re    = !i_empty && ((i_req.op == OP_WRITE) || (i_req.op == OP_READ));
                mem_raddr = i_addr0;
                n_valid   = !i_empty && (i_req.op == OP_NOP);
            end
            BS_READ: begin
                n_valid     = 1'b1;
                n_read_data = r_cur.hit0 ? r_rdata : 8'h00;
            end
            BS_WR0: begin
                mem_we    = r_cur.hit0;
                mem_waddr = r_addr0;
                mem_wdata = merge(r_rdata, r_cur.val0, r_cur.mask0);
                mem_re    = r_cur.hit1;
                mem_raddr = r_addr1;
                n_valid   = !r_cur.hit1;
            end
            BS_WR1: begin
                mem_we    = r_cur.hit1;
                mem_waddr = r_addr1;
                mem_wdata = merge(r_rdata, r_cur.val1, r_cur.mask1);
                n_valid   = 1'b1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_CLEAR;
            r_clr_addr <= '0;
            r_clr_cmd  <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (r_state == BS_CLEAR) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + 1'b1;
                if (clr_last) r_clr_cmd <= 1'b0;
            end else if (o_pop && (i_req.op == OP_CLEAR)) begin
                r_clr_cmd <= 1'b1;
            end
        end
    end

    // Current request and result payload
    always_ff @(posedge i_clk) begin
        r_read_data <= n_read_data;
        if (o_pop) begin
            r_cur   <= i_req;
            r_addr0 <= i_addr0;
            r_addr1 <= i_addr1;
        end
    end

    // Frame store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    a_port_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("frame store read and write hit the same byte");

    a_no_pop_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_CLEAR) |-> !o_pop)
        else $error("request popped during clearing sweep");

    a_sweep_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == BS_CLEAR) && clr_last) |=> ((r_clr_addr == '0) && (r_state == BS_IDLE)))
        else $error("clearing sweep did not end cleanly");

endmodule

`default_nettype wire

[design/page_framebuffer_bit_writer_top.sv]
// Top level of the page-organized monochrome frame buffer bit writer.
`default_nettype none

// Requests enter on start while busy is low and go through a two-entry queue to
// the memory engine, which owns a frame store of PAGES*COLUMNS bytes with one
// write port and a registered read port. Every request gives exactly one result,
// a one-cycle pulse on o_valid with o_read_data (zero for anything but a read);
// the receiver cannot stall it. The engine reads a written byte as it dequeues
// the request and merges it back in BS_WR0; a write that straddles two pages
// reads the second byte in BS_WR0 and writes it back in BS_WR1. A clear sweeps
// the store one byte per cycle. After reset a clearing pass over all
// PAGES*COLUMNS bytes (1024 by default) holds busy high.
module page_framebuffer_bit_writer_top import pfbw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_x,
    input  wire logic [7:0] i_y,
    input  wire logic [7:0] i_data,
    input  wire logic [3:0] i_len,
    input  wire logic       i_invert,
    output logic            o_valid,
    output logic [7:0]      o_read_data
);

    localparam int ADDR_W = $clog2(COLUMNS * PAGES);

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    logic              init_busy;
    t_req              f_req;
    t_req              q_req;
    logic [ADDR_W-1:0] f_addr0;
    logic [ADDR_W-1:0] f_addr1;
    logic [ADDR_W-1:0] q_addr0;
    logic [ADDR_W-1:0] q_addr1;

    // Request decode
    pfbw_front #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES),
        .ADDR_W  (ADDR_W)
    ) u_front (
        .i_start     (start),
        .i_command   (i_command),
        .i_x         (i_x),
        .i_y         (i_y),
        .i_data      (i_data),
        .i_len       (i_len),
        .i_invert    (i_invert),
        .i_q_full    (q_full),
        .i_init_busy (init_busy),
        .o_busy      (busy),
        .o_push      (push),
        .o_req       (f_req),
        .o_addr0     (f_addr0),
        .o_addr1     (f_addr1)
    );

    // Request queue
    pfbw_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (f_req),
        .i_addr0 (f_addr0),
        .i_addr1 (f_addr1),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_req   (q_req),
        .o_addr0 (q_addr0),
        .o_addr1 (q_addr1)
    );

    // Memory engine
    pfbw_back #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES),
        .ADDR_W  (ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_req       (q_req),
        .i_addr0     (q_addr0),
        .i_addr1     (q_addr1),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_valid     (o_valid),
        .o_read_data (o_read_data)
    );

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the page frame buffer bit writer: queued requests, in-order read-back check.
`default_nettype none

module tb_top import pfbw_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS = COLUMNS_DEF;
    localparam int PAGES   = PAGES_DEF;
    localparam int ROWS    = PAGES * 8;

    // One request as it goes onto the command port
    typedef struct {
        t_cmd       cmd;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] data;
        logic [3:0] len;
        logic       inv;
    } t_pix_req;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic [1:0] i_command   = CMD_NONE;
    logic [7:0] i_x         = '0;
    logic [7:0] i_y         = '0;
    logic [7:0] i_data      = '0;
    logic [3:0] i_len       = '0;
    logic       i_invert    = 1'b0;
    logic       busy;
    logic       o_valid;
    logic [7:0] o_read_data;

    // Predicted frame store and the result bytes still owed by the block
    logic [7:0] pix_mem [PAGES*COLUMNS];
    logic [7:0] read_exp_q [$];
    t_pix_req   req_q [$];
    t_pix_req   cur_req;
    int         idle_pct = 0;
    int         fails    = 0;

    page_framebuffer_bit_writer_top #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_x         (i_x),
        .i_y         (i_y),
        .i_data      (i_data),
        .i_len       (i_len),
        .i_invert    (i_invert),
        .o_valid     (o_valid),
        .o_read_data (o_read_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Merge masked bits into one byte of the predicted store, skipping bytes off the store
    function automatic void merge_byte(int page, logic [7:0] col, logic [7:0] val,
                                       logic [7:0] mask);
        if (page < PAGES && col < COLUMNS && mask != 8'h00) begin
            pix_mem[page*COLUMNS + col] = (pix_mem[page*COLUMNS + col] & ~mask) | (val & mask);
        end
    endfunction

    function automatic void clear_store();
        foreach (pix_mem[i]) begin
            pix_mem[i] = 8'h00;
        end
    endfunction

    // Apply one request to the predicted store; returns the byte the block should report
    function automatic logic [7:0] apply_request(t_pix_req r);
        logic [3:0]  n;
        logic [15:0] mask;
        logic [15:0] bits;
        logic [7:0]  src;
        logic [7:0]  rd;
        rd = 8'h00;
        case (r.cmd)
            CMD_WRITE: begin
                n = (r.len > LEN_MAX) ? LEN_MAX : r.len;
                if (n != 4'd0) begin
                    src  = r.inv ? ~r.data : r.data;
                    mask = ((16'h0001 << n) - 16'h0001) << r.y[2:0];
                    bits = ({8'h00, src & BYTE_ONES} << r.y[2:0]) & mask;
                    merge_byte(int'(r.y[7:3]), r.x, bits[7:0], mask[7:0]);
                    merge_byte(int'(r.y[7:3]) + 1, r.x, bits[15:8], mask[15:8]);
                end
            end
            CMD_READ: begin
                if (r.y[7:3] < PAGES && r.x < COLUMNS)
                    rd = pix_mem[int'(r.y[7:3])*COLUMNS + r.x];
            end
            CMD_CLEAR: clear_store();
            default: ;
        endcase
        return rd;
    endfunction

    task automatic push_req(t_cmd cmd, logic [7:0] x, logic [7:0] y, logic [7:0] data,
                            logic [3:0] len, logic inv);
        t_pix_req r;
        r.cmd  = cmd;
        r.x    = x;
        r.y    = y;
        r.data = data;
        r.len  = len;
        r.inv  = inv;
        req_q.push_back(r);
    endtask

    // Random request: mostly in-range writes and reads on a few hot columns, some noise
    function automatic t_pix_req rand_request();
        t_pix_req r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)      r.cmd = CMD_WRITE;
        else if (pick < 93) r.cmd = CMD_READ;
        else if (pick < 95) r.cmd = CMD_CLEAR;
        else                r.cmd = CMD_NONE;
        pick = $urandom_range(0, 9);
        if (pick == 0)      r.x = 8'($urandom);
        else if (pick < 6)  r.x = 8'($urandom_range(0, 3));
        else                r.x = 8'($urandom_range(0, COLUMNS - 1));
        r.y    = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, ROWS - 1));
        r.data = 8'($urandom);
        r.len  = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
        r.inv  = 1'($urandom);
        return r;
    endfunction

    // Driver: predict on acceptance, then present the next request or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                read_exp_q.push_back(apply_request(cur_req));
            end
            if (!start || !busy) begin
                if (req_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    cur_req   = req_q.pop_front();
                    i_command <= cur_req.cmd;
                    i_x       <= cur_req.x;
                    i_y       <= cur_req.y;
                    i_data    <= cur_req.data;
                    i_len     <= cur_req.len;
                    i_invert  <= cur_req.inv;
                    start     <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each result pulse is checked against the oldest predicted byte
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (read_exp_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %02h",
                         $time, o_read_data);
                fails++;
            end else if (o_read_data !== read_exp_q[0]) begin
                $display("%0t: read_data mismatch, expected %02h, actual %02h",
                         $time, read_exp_q[0], o_read_data);
                fails++;
                void'(read_exp_q.pop_front());
            end else begin
                void'(read_exp_q.pop_front());
            end
        end
    end

    // Hold off new requests until everything issued has been answered
    task automatic wait_drained();
        while (req_q.size() != 0 || start || read_exp_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random(int pct, int count);
        idle_pct = pct;
        repeat (count) req_q.push_back(rand_request());
        wait_drained();
    endtask

    initial begin
        clear_store();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pixel set, byte write, page straddle, invert, length corners,
        // last page overrun, out-of-range column and row, unused command, clear
        idle_pct = 0;
        push_req(CMD_READ,  8'd0,   8'd0,   8'h00, 4'd0,  1'b0);
        push_req(CMD_WRITE, 8'd0,   8'd0,   8'h01, 4'd1,  1'b0);
        push_req(CMD_READ,  8'd0,   8'd0,   8'h00, 4'd0,  1'b0);
        push_req(CMD_WRITE, 8'd127, 8'd56,  8'ha5, 4'd8,  1'b0);
        push_req(CMD_READ,  8'd127, 8'd63,  8'h00, 4'd0,  1'b0);
        push_req(CMD_WRITE, 8'd5,   8'd13,  8'hff, 4'd8,  1'b0);
        push_req(CMD_READ,  8'd5,   8'd8,   8'h00, 4'd0,  1'b0);
        push_req(CMD_READ,  8'd5,   8'd16,  8'h00, 4'd0,  1'b0);
        push_req(CMD_WRITE, 8'd5,   8'd14,  8'h00, 4'd3,  1'b1);
        push_req(CMD_WRITE, 8'd5,   8'd8,   8'h00, 4'd0,  1'b0);
        push_req(CMD_READ,  8'd5,   8'd8,   8'h00, 4'd0,  1'b0);
        push_req(CMD_WRITE, 8'd6,   8'd2,   8'hff, 4'd15, 1'b0);
        push_req(CMD_READ,  8'd6,   8'd8,   8'h00, 4'd0,  1'b0);
        push_req(CMD_WRITE, 8'd7,   8'd60,  8'hff, 4'd8,  1'b1);
        push_req(CMD_WRITE, 8'd7,   8'd60,  8'hff, 4'd8,  1'b0);
        push_req(CMD_READ,  8'd7,   8'd63,  8'h00, 4'd0,  1'b0);
        push_req(CMD_WRITE, 8'd255, 8'd0,   8'hff, 4'd8,  1'b0);
        push_req(CMD_WRITE, 8'd9,   8'd255, 8'hff, 4'd8,  1'b0);
        push_req(CMD_READ,  8'd200, 8'd0,   8'h00, 4'd0,  1'b0);
        push_req(CMD_READ,  8'd9,   8'd200, 8'h00, 4'd0,  1'b0);
        push_req(CMD_NONE,  8'd5,   8'd8,   8'hff, 4'd8,  1'b1);
        push_req(CMD_CLEAR, 8'd0,   8'd0,   8'h00, 4'd0,  1'b0);
        push_req(CMD_READ,  8'd5,   8'd8,   8'h00, 4'd0,  1'b0);
        push_req(CMD_READ,  8'd127, 8'd56,  8'h00, 4'd0,  1'b0);
        wait_drained();

        // Random traffic under changing sender idle rates
        run_random(0,  440);
        run_random(72, 440);
        run_random(0,  430);
        run_random(36, 440);

        repeat (20) @(posedge i_clk);
        if (fails == 0 && read_exp_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire

[page_framebuffer_bit_writer_top.f]
design/pfbw_pkg.sv
design/pfbw_front.sv
design/pfbw_queue.sv
design/pfbw_back.sv
design/page_framebuffer_bit_writer_top.sv
tb/tb_top.sv
